@@ design/spfs_pkg.sv @@
// ----------------------------------------------------------------------------
// spfs_pkg
// Shared widths, codes and reset values of the servo pulse frame sequencer.
// ----------------------------------------------------------------------------
package spfs_pkg;

    localparam int SLOTS_DEFAULT = 8;

    // Input beat
    localparam int CMD_W   = 2;
    localparam int WIDTH_W = 16;

    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WIDTH  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ATTACH = 2'd2;

    // Result beat
    localparam int PHASE_W = 2;

    localparam logic [PHASE_W-1:0] PH_IDLE  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_PULSE = 2'd1;
    localparam logic [PHASE_W-1:0] PH_GAP   = 2'd2;

    // Timing
    localparam int              TIME_W   = 20;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // Configuration registers
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int SCAN_W     = 4;
    localparam int GAP_W      = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REFRESH_PERIOD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MINIMUM_GAP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_FLOOR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_CEILING  = 3'd4;

    localparam logic [SCAN_W-1:0]  RST_SLOTS_IN_USE   = 4'd8;
    localparam logic [TIME_W-1:0]  RST_REFRESH_PERIOD = 20'd20000;
    localparam logic [GAP_W-1:0]   RST_MINIMUM_GAP    = 16'd1;
    localparam logic [WIDTH_W-1:0] RST_PULSE_FLOOR    = 16'd544;
    localparam logic [WIDTH_W-1:0] RST_PULSE_CEILING  = 16'd2400;
    localparam logic [WIDTH_W-1:0] RST_PULSE_WIDTH    = 16'd1500;

    // Width of a slot address
    function automatic int slot_bits(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    // Width of a slot number that can also hold "no slot"
    function automatic int active_bits(input int n);
        return $clog2(n + 1);
    endfunction

endpackage

@@ design/spfs_if.sv @@
// ----------------------------------------------------------------------------
// spfs channel interfaces
// Command channel and result channel, valid/ready with payload.
// ----------------------------------------------------------------------------
interface spfs_cmd_if #(
    parameter int SLOTS = spfs_pkg::SLOTS_DEFAULT
);
    import spfs_pkg::*;

    localparam int SLOT_W = slot_bits(SLOTS);

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [SLOT_W-1:0]  slot;
    logic [WIDTH_W-1:0] pulse_width;
    logic               attach;

    modport source (output valid, command, slot, pulse_width, attach, input ready);
    modport sink   (input valid, command, slot, pulse_width, attach, output ready);

endinterface

interface spfs_res_if #(
    parameter int SLOTS = spfs_pkg::SLOTS_DEFAULT
);
    import spfs_pkg::*;

    localparam int ACT_W = active_bits(SLOTS);

    logic               valid;
    logic               ready;
    logic [SLOTS-1:0]   servo_levels;
    logic [PHASE_W-1:0] phase;
    logic [ACT_W-1:0]   active_slot;
    logic               running;

    modport source (output valid, servo_levels, phase, active_slot, running, input ready);
    modport sink   (input valid, servo_levels, phase, active_slot, running, output ready);

endinterface

@@ design/servo_pulse_frame_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// servo_pulse_frame_sequencer_core
// Multi-channel RC servo pulse frame sequencer driven by timer-tick beats.
//
//   channel | dir | handshake    | payload
//   --------+-----+--------------+-------------------------------------------
//   cmd     | in  | valid/ready  | command, slot, pulse_width, attach
//   res     | out | valid/ready  | servo_levels, phase, active_slot, running
//   cfg     | in  | cfg_we       | cfg_index, cfg_wdata (write only)
//
// Every command beat yields exactly one result beat. A beat is taken in any
// cycle while the skid entry is empty; its result shows on res the next
// cycle, or waits in the skid entry while res is stalled.
// The result register plus one skid entry let the input take one more beat
// while res is stalled; cmd.ready drops only when both are full.
// Reset clears the schedule to idle, detaches all slots and loads every
// pulse width with 1500 ticks and the registers with their defaults.
// ----------------------------------------------------------------------------
module servo_pulse_frame_sequencer_core #(
    parameter int SLOTS = spfs_pkg::SLOTS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [spfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [spfs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    spfs_cmd_if.sink                        cmd,
    spfs_res_if.source                      res
);
    import spfs_pkg::*;

    localparam int ACT_W = active_bits(SLOTS);
    localparam int RES_W = SLOTS + PHASE_W + ACT_W + 1;

    logic               fire;
    logic [SLOTS-1:0]   levels_next;
    logic [PHASE_W-1:0] phase_next;
    logic [ACT_W-1:0]   cur_next;
    logic               run_next;
    logic [RES_W-1:0]   res_data;

    assign fire = cmd.valid && cmd.ready;

    spfs_engine #(
        .SLOTS (SLOTS)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .fire        (fire),
        .command     (cmd.command),
        .slot        (cmd.slot),
        .pulse_width (cmd.pulse_width),
        .attach      (cmd.attach),
        .levels_next (levels_next),
        .phase_next  (phase_next),
        .cur_next    (cur_next),
        .run_next    (run_next)
    );

    spfs_skid #(
        .DATA_W (RES_W)
    ) u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .in_data   ({levels_next, phase_next, cur_next, run_next}),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .out_data  (res_data)
    );

    assign res.servo_levels = res_data[RES_W-1 -: SLOTS];
    assign res.phase        = res_data[ACT_W+1 +: PHASE_W];
    assign res.active_slot  = res_data[1 +: ACT_W];
    assign res.running      = res_data[0];

endmodule

@@ design/spfs_engine.sv @@
// ----------------------------------------------------------------------------
// spfs_engine
// Frame scheduler state, configuration registers and next-state logic.
// ----------------------------------------------------------------------------
module spfs_engine #(
    parameter int SLOTS = spfs_pkg::SLOTS_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [spfs_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [spfs_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  logic                                   fire,
    input  logic [spfs_pkg::CMD_W-1:0]             command,
    input  logic [spfs_pkg::slot_bits(SLOTS)-1:0]  slot,
    input  logic [spfs_pkg::WIDTH_W-1:0]           pulse_width,
    input  logic                                   attach,
    output logic [SLOTS-1:0]                       levels_next,
    output logic [spfs_pkg::PHASE_W-1:0]           phase_next,
    output logic [spfs_pkg::active_bits(SLOTS)-1:0] cur_next,
    output logic                                   run_next
);
    import spfs_pkg::*;

    localparam int SLOT_W = slot_bits(SLOTS);
    localparam int ACT_W  = active_bits(SLOTS);
    localparam int CMP_W  = 6;

    localparam logic [ACT_W-1:0] NO_SLOT   = ACT_W'(SLOTS);
    localparam logic [CMP_W-1:0] SLOTS_CMP = CMP_W'(SLOTS);

    // Configuration
    logic [SCAN_W-1:0]  slots_in_use_reg;
    logic [TIME_W-1:0]  refresh_period_reg;
    logic [GAP_W-1:0]   minimum_gap_reg;
    logic [WIDTH_W-1:0] pulse_floor_reg;
    logic [WIDTH_W-1:0] pulse_ceiling_reg;

    // Scheduler state
    logic [WIDTH_W-1:0] table_reg [SLOTS];
    logic [WIDTH_W-1:0] table_next [SLOTS];
    logic [SLOTS-1:0]   attached_reg, attached_next;
    logic [SLOTS-1:0]   level_reg;
    logic [PHASE_W-1:0] phase_reg;
    logic [ACT_W-1:0]   cur_reg;
    logic [TIME_W-1:0]  ticks_reg, ticks_next;
    logic [TIME_W-1:0]  ilen_reg, ilen_next;
    logic [TIME_W-1:0]  ftime_reg, ftime_next;
    logic               run_reg;

    // Helpers
    logic [CMP_W-1:0]   scan_cnt;
    logic [SLOTS-1:0]   scan_mask;
    logic               slot_ok;
    logic [CMP_W-1:0]   next_cnt;
    logic               next_in_scan;
    logic [SLOT_W-1:0]  next_idx;
    logic               cur_ok;
    logic [SLOT_W-1:0]  cur_idx;
    logic [WIDTH_W-1:0] w_clamped;
    logic [TIME_W:0]    ft_sum;
    logic [TIME_W-1:0]  ft_sat;
    logic [TIME_W-1:0]  gap_raw;
    logic [TIME_W-1:0]  gap_len;
    logic [WIDTH_W-1:0] next_width;
    logic [TIME_W-1:0]  next_len;
    logic [WIDTH_W-1:0] width0;
    logic [TIME_W-1:0]  len0;
    logic               frame_ok;
    logic               do_start;
    logic               do_stop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_in_use_reg   <= RST_SLOTS_IN_USE;
            refresh_period_reg <= RST_REFRESH_PERIOD;
            minimum_gap_reg    <= RST_MINIMUM_GAP;
            pulse_floor_reg    <= RST_PULSE_FLOOR;
            pulse_ceiling_reg  <= RST_PULSE_CEILING;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SLOTS_IN_USE:   slots_in_use_reg   <= cfg_wdata[SCAN_W-1:0];
                REG_REFRESH_PERIOD: refresh_period_reg <= cfg_wdata[TIME_W-1:0];
                REG_MINIMUM_GAP:    minimum_gap_reg    <= cfg_wdata[GAP_W-1:0];
                REG_PULSE_FLOOR:    pulse_floor_reg    <= cfg_wdata[WIDTH_W-1:0];
                REG_PULSE_CEILING:  pulse_ceiling_reg  <= cfg_wdata[WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    // Scan window
    always_comb
    begin
        if (CMP_W'(slots_in_use_reg) > SLOTS_CMP)
            scan_cnt = SLOTS_CMP;
        else
            scan_cnt = CMP_W'(slots_in_use_reg);
        for (int i = 0; i < SLOTS; i++)
            scan_mask[i] = (CMP_W'(i) < scan_cnt);
    end

    assign slot_ok      = (CMP_W'(slot) < SLOTS_CMP);
    assign next_cnt     = CMP_W'(cur_reg) + CMP_W'(1);
    assign next_in_scan = (next_cnt < scan_cnt);
    assign next_idx     = next_cnt[SLOT_W-1:0];
    assign cur_ok       = (CMP_W'(cur_reg) < SLOTS_CMP);
    assign cur_idx      = cur_reg[SLOT_W-1:0];

    // When the limits cross, widths below the floor take the floor and all others the ceiling
    assign w_clamped = (pulse_width < pulse_floor_reg)   ? pulse_floor_reg :
                       (pulse_width > pulse_ceiling_reg) ? pulse_ceiling_reg :
                                                           pulse_width;

    // Frame time after the current pulse, saturated
    assign ft_sum = {1'b0, ftime_reg} + {1'b0, ilen_reg};
    assign ft_sat = ft_sum[TIME_W] ? TIME_MAX : ft_sum[TIME_W-1:0];

    assign gap_raw = (ft_sat < refresh_period_reg) ? (refresh_period_reg - ft_sat)
                                                   : TIME_W'(minimum_gap_reg);
    assign gap_len = (gap_raw == '0) ? TIME_W'(1) : gap_raw;

    assign next_width = next_in_scan ? table_reg[next_idx] : '0;
    assign next_len   = (next_width == '0) ? TIME_W'(1) : TIME_W'(next_width);

    // Slot 0 width as seen by a frame start, including a same-beat write
    assign width0 = (command == CMD_WIDTH && slot_ok && slot == '0) ? w_clamped
                                                                    : table_reg[0];
    assign len0   = (width0 == '0) ? TIME_W'(1) : TIME_W'(width0);

    assign frame_ok = |(attached_next & scan_mask);

    always_comb
    begin
        table_next    = table_reg;
        attached_next = attached_reg;
        levels_next   = level_reg;
        phase_next    = phase_reg;
        cur_next      = cur_reg;
        ticks_next    = ticks_reg;
        ilen_next     = ilen_reg;
        ftime_next    = ftime_reg;
        run_next      = run_reg;
        do_start      = 1'b0;
        do_stop       = 1'b0;

        case (command)
            CMD_TICK:
            begin
                if (run_reg)
                begin
                    if (ticks_reg > TIME_W'(1))
                        ticks_next = ticks_reg - TIME_W'(1);
                    else
                    begin
                        ticks_next = '0;
                        if (phase_reg == PH_PULSE && cur_ok)
                        begin
                            levels_next[cur_idx] = 1'b0;
                            ftime_next = ft_sat;
                            if (next_in_scan)
                            begin
                                cur_next   = ACT_W'(next_cnt);
                                phase_next = PH_PULSE;
                                ilen_next  = next_len;
                                ticks_next = next_len;
                                if (attached_reg[next_idx])
                                    levels_next[next_idx] = 1'b1;
                            end
                            else
                            begin
                                cur_next   = NO_SLOT;
                                phase_next = PH_GAP;
                                ilen_next  = gap_len;
                                ticks_next = gap_len;
                            end
                        end
                        else if (phase_reg == PH_GAP)
                            do_start = 1'b1;
                        else
                            do_stop = 1'b1;
                    end
                end
            end
            CMD_WIDTH:
            begin
                if (slot_ok)
                begin
                    table_next[slot] = w_clamped;
                    if (attached_reg[slot] && !run_reg)
                        do_start = 1'b1;
                end
            end
            CMD_ATTACH:
            begin
                if (slot_ok)
                begin
                    levels_next[slot]   = 1'b0;
                    attached_next[slot] = attach;
                    if (attach)
                        do_start = !run_reg;
                    else
                        do_stop = !frame_ok;
                end
            end
            default: ;
        endcase

        if (do_start && frame_ok)
        begin
            run_next   = 1'b1;
            ftime_next = '0;
            cur_next   = '0;
            phase_next = PH_PULSE;
            ilen_next  = len0;
            ticks_next = len0;
            if (attached_next[0])
                levels_next[0] = 1'b1;
        end
        else if (do_stop || do_start)
        begin
            run_next    = 1'b0;
            phase_next  = PH_IDLE;
            cur_next    = NO_SLOT;
            ilen_next   = '0;
            ticks_next  = '0;
            levels_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                table_reg[i] <= RST_PULSE_WIDTH;
            attached_reg <= '0;
            level_reg    <= '0;
            phase_reg    <= PH_IDLE;
            cur_reg      <= NO_SLOT;
            ticks_reg    <= '0;
            ilen_reg     <= '0;
            ftime_reg    <= '0;
            run_reg      <= 1'b0;
        end
        else if (fire)
        begin
            table_reg    <= table_next;
            attached_reg <= attached_next;
            level_reg    <= levels_next;
            phase_reg    <= phase_next;
            cur_reg      <= cur_next;
            ticks_reg    <= ticks_next;
            ilen_reg     <= ilen_next;
            ftime_reg    <= ftime_next;
            run_reg      <= run_next;
        end
    end

endmodule

@@ design/spfs_skid.sv @@
// ----------------------------------------------------------------------------
// spfs_skid
// Result register with a skid stage so the input side keeps moving while a
// result waits.
// ----------------------------------------------------------------------------
module spfs_skid #(
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);
    logic              out_valid_reg;
    logic              skid_valid_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic [DATA_W-1:0] skid_data_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // drain the skid stage into the result register
            if (out_ready)
                skid_valid_reg <= 1'b0;
        end
        else if (in_valid)
        begin
            out_valid_reg <= 1'b1;
            if (out_valid_reg && !out_ready)
                skid_valid_reg <= 1'b1;
        end
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_ready)
                out_data_reg <= skid_data_reg;
        end
        else if (in_valid)
        begin
            if (out_valid_reg && !out_ready)
                skid_data_reg <= in_data;
            else
                out_data_reg <= in_data;
        end
    end

endmodule

@@ design/spfs_checker.sv @@
// ----------------------------------------------------------------------------
// spfs_checker
// Port-level checks of the servo pulse frame sequencer, bound to the core.
// ----------------------------------------------------------------------------
module spfs_checker #(
    parameter int SLOTS = spfs_pkg::SLOTS_DEFAULT
) (
    input logic                                    clk,
    input logic                                    rst_n,
    input logic                                    cmd_ready,
    input logic                                    res_valid,
    input logic                                    res_ready,
    input logic [SLOTS-1:0]                        res_levels,
    input logic [spfs_pkg::PHASE_W-1:0]            res_phase,
    input logic [spfs_pkg::active_bits(SLOTS)-1:0] res_active_slot,
    input logic                                    res_running
);
    import spfs_pkg::*;

    localparam int               ACT_W   = active_bits(SLOTS);
    localparam logic [ACT_W-1:0] NO_SLOT = ACT_W'(SLOTS);

    // A stalled result beat holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_levels)
            && $stable(res_phase) && $stable(res_active_slot) && $stable(res_running))
        else $error("result beat changed while stalled");

    // An empty result side never back-pressures the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> cmd_ready)
        else $error("input stalled with no result pending");

    // Stopped scheduler shows idle, no slot, all outputs low
    a_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_running |->
            res_phase == PH_IDLE && res_active_slot == NO_SLOT && res_levels == '0)
        else $error("stopped scheduler shows activity");

    // Refresh gap drives nothing
    a_gap_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_phase == PH_GAP |->
            res_running && res_active_slot == NO_SLOT && res_levels == '0)
        else $error("output high during refresh gap");

    // At most one servo output is high during a pulse, and a slot is being timed
    a_one_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_phase == PH_PULSE |->
            res_running && $countones(res_levels) <= 1 && res_active_slot != NO_SLOT)
        else $error("more than one servo output high");

endmodule

bind servo_pulse_frame_sequencer_core spfs_checker #(
    .SLOTS (SLOTS)
) u_spfs_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_ready       (cmd.ready),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .res_levels      (res.servo_levels),
    .res_phase       (res.phase),
    .res_active_slot (res.active_slot),
    .res_running     (res.running)
);
